// ===== sv/nlf_pkg.sv =====
// shared constants and types for the newline line framer
package nlf_pkg;

    // line store geometry
    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

    // field widths
    localparam int BYTE_W     = 8;
    localparam int M_DATA_W   = ((BYTE_W + LEN_W + 7) / 8) * 8;

    // byte value that ends a line
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } nlf_state_t;

endpackage

// ===== sv/newline_line_framer_unit.sv =====
// top level: gathers serial bytes into a line store and streams out each completed line
// a byte that is not a newline is stored in the line store and s_tready stays high.
// a newline starts readout: each byte of the line takes a registered read of the
// single-port line store, then an output state that waits while m_tready is low;
// input is held off until the last byte (tlast) is transferred.
// reset (aresetn low, synchronous) empties the line and returns to idle; the line
// store itself is not cleared since only entries of the current line are ever read.
module newline_line_framer_unit
    import nlf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // [7:0] line_byte, [14:8] line_length, rest zero
    output logic                 m_tlast    // is_last
);

    nlf_state_t           state_reg, state_next;
    logic [LEN_W-1:0]     fill_count_reg, fill_count_next;
    logic [LEN_W-1:0]     line_len_reg, line_len_next;
    logic [ADDR_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [BYTE_W-1:0]    rd_data_reg;
    logic [BYTE_W-1:0]    line_store [LINE_DEPTH];

    logic                 s_xfer;
    logic                 m_xfer;
    logic [ADDR_W-1:0]    wr_pos;
    logic [LEN_W-1:0]     wr_len;
    logic                 rd_is_last;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    // write position, with an out-of-range count folded back to zero
    always_comb begin
        if (fill_count_reg >= LEN_W'(LINE_DEPTH)) begin
            wr_pos = '0;
        end else begin
            wr_pos = fill_count_reg[ADDR_W-1:0];
        end
    end
    assign wr_len     = LEN_W'(wr_pos) + LEN_W'(1);
    assign rd_is_last = (LEN_W'(rd_idx_reg) + LEN_W'(1)) == line_len_reg;

    // line store: one write per input transfer, registered read during readout
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            line_store[wr_pos] <= s_tdata;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= line_store[rd_idx_reg];
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        line_len_next   = line_len_reg;
        rd_idx_next     = rd_idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tdata == NEWLINE_CODE) begin
                        line_len_next   = wr_len;
                        rd_idx_next     = '0;
                        fill_count_next = '0;
                        state_next      = ST_READ;
                    end else if (wr_len >= LEN_W'(LINE_DEPTH)) begin
                        // store full without a newline: drop the partial line
                        fill_count_next = '0;
                    end else begin
                        fill_count_next = wr_len;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_xfer) begin
                    if (rd_is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + ADDR_W'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            line_len_reg   <= '0;
            rd_idx_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            line_len_reg   <= line_len_next;
            rd_idx_reg     <= rd_idx_next;
        end
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tlast  = rd_is_last;
    assign m_tdata  = M_DATA_W'({line_len_reg, rd_data_reg});

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a line is being sent");

    a_newline_starts_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tdata == NEWLINE_CODE) |=> (!s_tready && !m_tvalid))
        else $error("newline transfer did not start line readout");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast) |=> (s_tready && fill_count_reg == '0))
        else $error("framer not idle and empty after last byte");

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg < LEN_W'(LINE_DEPTH))
        else $error("fill count out of range");

    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (line_len_reg != '0 && LEN_W'(rd_idx_reg) < line_len_reg))
        else $error("readout index beyond line length");

endmodule

// ===== dv/newline_line_framer_unit_tb.sv =====
// testbench for newline_line_framer_unit: random and edge-case lines, every output byte checked
module newline_line_framer_unit_tb;
    import nlf_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 2 * LINE_DEPTH + 16;

    // one expected output transfer
    typedef struct packed {
        logic [BYTE_W-1:0] line_byte;
        logic [LEN_W-1:0]  line_length;
        logic              is_last;
    } line_beat_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [BYTE_W-1:0]   s_tdata  = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    // stimulus and idling control
    logic [BYTE_W-1:0] rx_pending[$];
    int unsigned       tx_idle_pct  = 0;
    int unsigned       rx_stall_pct = 0;
    bit                hold_arm     = 1'b0;
    bit                hold_seen    = 1'b0;
    int unsigned       hold_left    = 0;

    // shadow of the line store and the expected output beats
    logic [BYTE_W-1:0] shadow_line[LINE_DEPTH];
    int unsigned       shadow_fill  = 0;
    line_beat_t        line_expect[$];
    int unsigned       mismatch_cnt = 0;
    int unsigned       cycle_cnt    = 0;

    newline_line_framer_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // store one accepted byte and, on a newline, queue the whole line
    function automatic void frame_rx_byte(logic [BYTE_W-1:0] b);
        int unsigned pos;
        int unsigned k;
        line_beat_t  beat;
        pos = (shadow_fill >= LINE_DEPTH) ? 0 : shadow_fill;
        shadow_line[pos] = b;
        if (b == NEWLINE_CODE) begin
            for (k = 0; k <= pos; k++) begin
                beat.line_byte   = shadow_line[k];
                beat.line_length = LEN_W'(pos + 1);
                beat.is_last     = (k == pos);
                line_expect.push_back(beat);
            end
            shadow_fill = 0;
        end else if (pos + 1 >= LINE_DEPTH) begin
            // store full with no newline: line is dropped
            shadow_fill = 0;
        end else begin
            shadow_fill = pos + 1;
        end
    endfunction

    // random byte that is never a newline
    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        if (b == NEWLINE_CODE) begin
            b = ~NEWLINE_CODE;
        end
        return b;
    endfunction

    task automatic queue_line(int unsigned body_len, bit close_line);
        int unsigned i;
        for (i = 0; i < body_len; i++) begin
            rx_pending.push_back(text_byte());
        end
        if (close_line) begin
            rx_pending.push_back(NEWLINE_CODE);
        end
    endtask

    // mostly well-formed lines, some stray bytes and some overlong runs
    task automatic queue_traffic(int unsigned n_items);
        int unsigned start;
        int unsigned roll;
        start = rx_pending.size();
        while (rx_pending.size() - start < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                queue_line($urandom_range(0, 11), 1'b1);
            end else if (roll < 80) begin
                queue_line($urandom_range(12, LINE_DEPTH - 1), 1'b1);
            end else if (roll < 95) begin
                rx_pending.push_back(BYTE_W'($urandom_range(0, 255)));
            end else begin
                queue_line(LINE_DEPTH, 1'b0);
            end
        end
    endtask

    task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // wait until every byte is sent and every line beat has come out
    task automatic wait_drained();
        while (rx_pending.size() != 0 || s_tvalid || line_expect.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // input driver: next byte only after the current transfer or while idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                frame_rx_byte(s_tdata);
            end
            if (!s_tvalid || s_tready) begin
                if (rx_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_pending.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started by toggling hold_arm
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_arm;
        end
    end

    // output monitor and ready generation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (line_expect.size() == 0) begin
                $error("unexpected output transfer: data %0h last %0b", m_tdata, m_tlast);
                mismatch_cnt = mismatch_cnt + 1;
            end else begin
                automatic line_beat_t want = line_expect.pop_front();
                if (m_tdata[BYTE_W-1:0] !== want.line_byte) begin
                    $error("line_byte: expected %0h, got %0h",
                           want.line_byte, m_tdata[BYTE_W-1:0]);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (m_tdata[BYTE_W +: LEN_W] !== want.line_length) begin
                    $error("line_length: expected %0d, got %0d",
                           want.line_length, m_tdata[BYTE_W +: LEN_W]);
                    mismatch_cnt = mismatch_cnt + 1;
                end
                if (m_tlast !== want.is_last) begin
                    $error("is_last: expected %0b, got %0b", want.is_last, m_tlast);
                    mismatch_cnt = mismatch_cnt + 1;
                end
            end
        end
        m_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sequence of test phases
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // edge cases: lone newline, extreme byte values, newline in the last
        // slot, full store without newline followed by a fresh line
        set_idling(0, 0);
        rx_pending.push_back(NEWLINE_CODE);
        rx_pending.push_back(8'h00);
        rx_pending.push_back(8'hFF);
        rx_pending.push_back(NEWLINE_CODE);
        rx_pending.push_back(8'd9);
        rx_pending.push_back(8'd11);
        rx_pending.push_back(NEWLINE_CODE);
        queue_line(LINE_DEPTH - 1, 1'b1);
        queue_line(LINE_DEPTH, 1'b0);
        rx_pending.push_back(NEWLINE_CODE);
        wait_drained();

        // random traffic under several idling mixes
        set_idling(0, 0);
        queue_traffic(6);
        wait_drained();
        set_idling(88, 0);
        queue_traffic(6);
        wait_drained();
        set_idling(0, 88);
        queue_traffic(6);
        wait_drained();
        set_idling(9, 9);
        queue_traffic(6);
        wait_drained();

        // receiver blocked for a long stretch while bytes keep coming
        set_idling(0, 0);
        hold_arm = ~hold_arm;
        queue_line(3, 1'b1);
        queue_line(3, 1'b1);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/nlf_pkg.sv
sv/newline_line_framer_unit.sv
dv/newline_line_framer_unit_tb.sv
